### rtl/core/ett_pkg.sv
// Shared types and constants for the expiring ticket table.
// Used by the cell row, the top level and the port checker.
`timescale 1ns / 1ps

package ett_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [15:0] LIFE_RESET = 16'd60;

    // request kinds
    localparam logic [1:0] REQ_ISSUE   = 2'd0;
    localparam logic [1:0] REQ_CONSUME = 2'd1;
    localparam logic [1:0] REQ_REVOKE  = 2'd2;

    // result status codes
    localparam logic [3:0] ST_ISSUED    = 4'd0;
    localparam logic [3:0] ST_NO_CAND   = 4'd1;
    localparam logic [3:0] ST_DUPLICATE = 4'd2;
    localparam logic [3:0] ST_FULL      = 4'd3;
    localparam logic [3:0] ST_ACCEPTED  = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND = 4'd5;
    localparam logic [3:0] ST_EXPIRED   = 4'd6;
    localparam logic [3:0] ST_MISMATCH  = 4'd7;
    localparam logic [3:0] ST_REVOKED   = 4'd8;

    // request held for the whole walk along the row
    typedef struct packed {
        logic [1:0]          typ;
        logic                cand;
        logic [KEY_BITS-1:0] key;
        logic [31:0]         match_id;
        logic [31:0]         player_id;
        logic [31:0]         now;
    } t_req;

    // token handed from cell to cell
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [3:0]       status;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
    } t_tok;

    // broadcast write of a new ticket
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] slot;
        logic [31:0]      expiry;
    } t_commit;

endpackage

### rtl/core/ett_cell.sv
// One table entry of the expiring ticket table plus its token stage.
// Depends on ett_pkg for the request, token and commit types.
`timescale 1ns / 1ps

module ett_cell import ett_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_req             i_req,
    input  t_tok             i_tok,
    input  t_commit          i_commit,
    output t_tok             o_tok
);

    logic                r_valid;
    logic                n_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]         r_match;
    logic [31:0]         r_player;
    logic [31:0]         r_exp;
    t_tok                r_tok;
    t_tok                n_tok;

    logic purge;
    logic live;
    logic key_hit;
    logic clr;
    logic wr_here;

    assign wr_here = i_commit.en && (i_commit.slot == i_idx);

    always_comb begin
        purge   = i_tok.vld && (i_req.typ == REQ_ISSUE) && r_valid && (i_req.now >= r_exp);
        live    = r_valid && !purge;
        key_hit = live && (r_key == i_req.key);
        clr     = 1'b0;
        n_tok   = i_tok;
        if (i_tok.vld) begin
            case (i_req.typ)
                REQ_ISSUE: begin
                    if (key_hit) begin
                        n_tok.hit = 1'b1;
                    end
                    // remember the lowest free entry
                    if (!live && !i_tok.free_ok) begin
                        n_tok.free_ok  = 1'b1;
                        n_tok.free_idx = i_idx;
                    end
                end
                REQ_CONSUME: begin
                    if (key_hit) begin
                        n_tok.hit = 1'b1;
                        if (i_req.now >= r_exp) begin
                            n_tok.status = ST_EXPIRED;
                            clr          = 1'b1;
                        end else if (r_match != i_req.match_id ||
                                     r_player != i_req.player_id) begin
                            n_tok.status = ST_MISMATCH;
                        end else begin
                            n_tok.status = ST_ACCEPTED;
                            clr          = 1'b1;
                        end
                    end
                end
                REQ_REVOKE: begin
                    if (key_hit) begin
                        n_tok.hit = 1'b1;
                        clr       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        n_valid = (live && !clr) || wr_here;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_key    <= i_req.key;
            r_match  <= i_req.match_id;
            r_player <= i_req.player_id;
            r_exp    <= i_commit.expiry;
        end
    end

    assign o_tok = r_tok;

endmodule

### rtl/core/expiring_ticket_table.sv
// Top level of the expiring ticket table: request intake, row of entry cells,
// result register and lifetime register. Depends on ett_pkg and ett_cell.
`timescale 1ns / 1ps

// Usage
//   Requests enter on the s_axis channel, one item per handshake; every item
//   gives exactly one result item on the m_axis channel. tuser carries the
//   request kind and candidate flag in, and the status out.
//   The user must write the lifetime register with i_cfg_wr_en /
//   i_cfg_wr_data only while the block is idle; the block itself does not
//   enforce this. The lifetime resets to 60 seconds. After acceptance, a
//   token walks the row of TABLE_DEPTH cells, one cell a cycle: each cell
//   purges, matches or erases its own entry. A final step, taken once the
//   result register is free, stores a new ticket into the lowest free entry
//   and loads the result. One item is in the row at a time: intake reopens
//   only when the finished item moves into the result register.
//   The result register decouples the sides: a new item is accepted while a
//   result waits. If the receiver stalls, the next finished item holds until
//   the result register frees, and intake stops until then.
//   Synchronous reset empties the table, drops any item in flight and
//   restores the lifetime; intake stays closed while reset is held.

module expiring_ticket_table import ett_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] ticket_value, [95:64] match_id, [127:96] player_id,
    // [159:128] now_seconds
    input  logic [159:0] s_axis_tdata,
    // [1:0] req_type, [2] candidate_valid
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] ticket_echo
    output logic [63:0]  m_axis_tdata,
    // [3:0] status
    output logic [3:0]   m_axis_tuser,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    logic [15:0] r_life;
    t_req        r_req;
    logic [31:0] r_exp;
    logic        r_start;
    t_tok        r_fin;
    logic        r_m_valid;
    logic [63:0] r_m_echo;
    logic [3:0]  r_m_status;

    t_tok        w_tok [TABLE_DEPTH+1];
    t_commit     w_commit;
    logic        accept;
    logic        out_free;
    logic        finish;
    logic [3:0]  fin_status;
    logic        issue_ok;
    logic [32:0] exp_sum;

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign finish        = (r_state == S_DONE) && out_free;

    // saturating expiry of a ticket issued now
    assign exp_sum = {1'b0, s_axis_tdata[159:128]} + {17'd0, r_life};

    always_comb begin
        issue_ok   = 1'b0;
        fin_status = ST_NOT_FOUND;
        case (r_req.typ)
            REQ_ISSUE: begin
                if (!r_req.cand) begin
                    fin_status = ST_NO_CAND;
                end else if (r_fin.hit) begin
                    fin_status = ST_DUPLICATE;
                end else if (!r_fin.free_ok) begin
                    fin_status = ST_FULL;
                end else begin
                    fin_status = ST_ISSUED;
                    issue_ok   = 1'b1;
                end
            end
            REQ_CONSUME: fin_status = r_fin.hit ? r_fin.status : ST_NOT_FOUND;
            REQ_REVOKE:  fin_status = ST_REVOKED;
            default:     fin_status = ST_NOT_FOUND;
        endcase
    end

    assign w_commit.en     = finish && issue_ok;
    assign w_commit.slot   = r_fin.free_idx;
    assign w_commit.expiry = r_exp;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_RUN;
            S_RUN:   if (w_tok[TABLE_DEPTH].vld) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_life    <= LIFE_RESET;
            r_start   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= accept;
            if (i_cfg_wr_en) begin
                r_life <= i_cfg_wr_data;
            end
            if (finish) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.typ       <= s_axis_tuser[1:0];
            r_req.cand      <= s_axis_tuser[2];
            r_req.key       <= s_axis_tdata[KEY_BITS-1:0];
            r_req.match_id  <= s_axis_tdata[95:64];
            r_req.player_id <= s_axis_tdata[127:96];
            r_req.now       <= s_axis_tdata[159:128];
            r_exp           <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
        end
        // hold the token that left the row until the result register frees
        if (r_state == S_RUN && w_tok[TABLE_DEPTH].vld) begin
            r_fin <= w_tok[TABLE_DEPTH];
        end
        if (finish) begin
            r_m_status <= fin_status;
            r_m_echo   <= issue_ok ? 64'(r_req.key) : 64'd0;
        end
    end

    always_comb begin
        w_tok[0]          = '0;
        w_tok[0].vld      = r_start;
        w_tok[0].status   = ST_NOT_FOUND;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ett_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (IDX_W'(g)),
            .i_req    (r_req),
            .i_tok    (w_tok[g]),
            .i_commit (w_commit),
            .o_tok    (w_tok[g+1])
        );
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_echo;
    assign m_axis_tuser  = r_m_status;

endmodule

### rtl/core/ett_checker.sv
// Port-level checks for the expiring ticket table, bound to the top level.
// Depends on ett_pkg for the status codes.
`timescale 1ns / 1ps

module ett_checker import ett_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic [3:0]   m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one item at a time: intake closes right after an acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while busy");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_REVOKED)
        else $error("status code out of range");

    // key echo only with an issued ticket
    a_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_ISSUED |-> m_axis_tdata == 64'd0)
        else $error("echo set without issue");

endmodule

bind expiring_ticket_table ett_checker u_ett_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
